// ----- rtl/core/stb_pkg.sv -----
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and command codes for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned PeriodW = 16;

  // Command codes carried in the func field; codes above CHECK are no-ops.
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK       = 3'd0,
    FUNC_START_ONE  = 3'd1,
    FUNC_START_AUTO = 3'd2,
    FUNC_STOP       = 3'd3,
    FUNC_CHECK      = 3'd4
  } stb_func_e;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [IndexW-1:0]  timer_index;
    logic [PeriodW-1:0] period;
  } stb_in_t;

  typedef struct packed {
    logic expired;
    logic index_error;
  } stb_out_t;

  // Decoded command from controller to datapath, one-hot or all zero.
  // nop marks a transfer with an unused func code.
  typedef struct packed {
    logic tick;
    logic start_one;
    logic start_auto;
    logic stop;
    logic check;
    logic nop;
  } stb_cmd_t;

endpackage

// ----- rtl/core/stb_ctrl.sv -----
// ----------------------------------------------------------------------------
// stb_ctrl
// Handshake controller: output slot state, transfer acceptance, func decode.
// ----------------------------------------------------------------------------
module stb_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [stb_pkg::FuncW-1:0] func_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output stb_pkg::stb_cmd_t         cmd_o
);
  import stb_pkg::*;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Output slot frees up in the same cycle it drains.
  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_FULL);

  always_comb begin
    cmd_o = '0;
    if (accept) begin
      case (func_i)
        FUNC_TICK:       cmd_o.tick       = 1'b1;
        FUNC_START_ONE:  cmd_o.start_one  = 1'b1;
        FUNC_START_AUTO: cmd_o.start_auto = 1'b1;
        FUNC_STOP:       cmd_o.stop       = 1'b1;
        FUNC_CHECK:      cmd_o.check      = 1'b1;
        default:         cmd_o.nop        = 1'b1;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_FULL;
    end else if (out_ready_i) begin
      state_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/stb_datapath.sv -----
// ----------------------------------------------------------------------------
// stb_datapath
// Timer state, parallel tick decrement, command execution, result register.
// ----------------------------------------------------------------------------
module stb_datapath #(
  parameter int unsigned NUM_TIMERS  = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stb_pkg::stb_cmd_t           cmd_i,
  input  logic [stb_pkg::IndexW-1:0]  timer_index_i,
  input  logic [stb_pkg::PeriodW-1:0] period_i,
  output stb_pkg::stb_out_t           result_o
);
  import stb_pkg::*;

  logic [COUNT_WIDTH-1:0] remaining_q [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] remaining_d [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_q    [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_d    [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  auto_q, auto_d;
  logic [NUM_TIMERS-1:0]  flag_q, flag_d;
  logic [NUM_TIMERS-1:0]  sel;

  logic [COUNT_WIDTH-1:0] per;
  logic                   idx_ok;
  logic                   addressed;
  stb_out_t               result_q, result_d;

  assign per       = COUNT_WIDTH'(period_i);
  assign idx_ok    = {1'b0, timer_index_i} < (IndexW + 1)'(NUM_TIMERS);
  assign addressed = cmd_i.start_one || cmd_i.start_auto || cmd_i.stop || cmd_i.check;

  always_comb begin
    logic [COUNT_WIDTH-1:0] dec;
    for (int unsigned t = 0; t < NUM_TIMERS; t++) begin
      sel[t]         = idx_ok && (timer_index_i == IndexW'(t));
      remaining_d[t] = remaining_q[t];
      reload_d[t]    = reload_q[t];
      auto_d[t]      = auto_q[t];
      flag_d[t]      = flag_q[t];
      dec            = remaining_q[t] - COUNT_WIDTH'(1);
      if (cmd_i.tick && (remaining_q[t] != '0)) begin
        remaining_d[t] = dec;
        if (dec == '0) begin
          flag_d[t] = 1'b1;
          if (auto_q[t]) begin
            remaining_d[t] = reload_q[t];
          end
        end
      end else if (sel[t]) begin
        if (cmd_i.start_one) begin
          remaining_d[t] = per;
          reload_d[t]    = '0;
          auto_d[t]      = 1'b0;
          flag_d[t]      = 1'b0;
        end else if (cmd_i.start_auto) begin
          remaining_d[t] = per;
          reload_d[t]    = per;
          auto_d[t]      = 1'b1;
          flag_d[t]      = 1'b0;
        end else if (cmd_i.stop) begin
          remaining_d[t] = '0;
          reload_d[t]    = '0;
          auto_d[t]      = 1'b0;
          flag_d[t]      = 1'b0;
        end else if (cmd_i.check) begin
          flag_d[t] = 1'b0;
        end
      end
    end
  end

  // Result loads on every transfer; any command strobe marks one.
  always_comb begin
    result_d             = result_q;
    result_d.expired     = cmd_i.check && |(flag_q & sel);
    result_d.index_error = addressed && !idx_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned t = 0; t < NUM_TIMERS; t++) begin
        remaining_q[t] <= '0;
        reload_q[t]    <= '0;
      end
      auto_q <= '0;
      flag_q <= '0;
    end else begin
      for (int unsigned t = 0; t < NUM_TIMERS; t++) begin
        remaining_q[t] <= remaining_d[t];
        reload_q[t]    <= reload_d[t];
      end
      auto_q <= auto_d;
      flag_q <= flag_d;
    end
  end

  logic load_result;
  assign load_result = cmd_i.tick || cmd_i.nop || addressed;

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ----- rtl/core/software_timer_bank_top.sv -----
// ----------------------------------------------------------------------------
// software_timer_bank_top
// Bank of down-counting one-shot / auto-reload timers driven by commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one command per
//   transfer: tick, start one-shot, start auto-reload, stop, check-and-clear.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result per command: expired (check only) and index_error.
//   Latency: the result is valid the cycle after the command transfer.
//   Throughput: one command per cycle while out_ready_i is high. All timers
//   decrement in parallel on a tick, and the single output register drains
//   and refills in the same cycle, so its handshake loop sets the rate.
//   Stall: while out_ready_i is low and a result is pending, in_ready_o drops
//   and no command is taken; timer state is untouched until it resumes.
//   Reset: all counts, reload values, modes and flags clear; no result is
//   pending. Unused func codes change nothing and report zeros.
// ----------------------------------------------------------------------------
module software_timer_bank_top #(
  parameter int unsigned NUM_TIMERS  = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stb_pkg::stb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stb_pkg::stb_out_t out_data_o
);
  import stb_pkg::*;

  stb_cmd_t cmd;

  // Controller: output slot occupancy and command decode per transfer.
  stb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (in_data_i.func),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: per-timer registers and the result register.
  stb_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .timer_index_i (in_data_i.timer_index),
    .period_i      (in_data_i.period),
    .result_o      (out_data_o)
  );

endmodule
